// ===== hw/rtl/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int CODE_WIDTH   = 16;
  localparam int SYMBOL_COUNT = 256;
  localparam int SYM_BITS     = $clog2(SYMBOL_COUNT);
  localparam int LEN_BITS     = 5;
  localparam int BYTE_BITS    = 8;
  localparam int WIN_BITS     = BYTE_BITS + CODE_WIDTH;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  // One queued job for the packer: an encode with its looked-up code, or a flush.
  typedef struct packed {
    logic                    flush;
    logic [CODE_WIDTH-1:0]   code;
    logic [LEN_BITS-1:0]     len;
  } cmd_t;

  // Table entry: left-justified code and its length.
  typedef struct packed {
    logic [CODE_WIDTH-1:0]   code;
    logic [LEN_BITS-1:0]     len;
  } entry_t;

endpackage

// ===== hw/rtl/hcbp_if.sv =====
// ----------------------------------------------------------------------------
// hcbp_in_if / hcbp_out_if
// Valid/ready channels of the bit packer: input items and output bytes.
// ----------------------------------------------------------------------------
interface hcbp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] symbol;
  logic [15:0] code_bits;
  logic [4:0] code_length;

  modport source (output valid, kind, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, kind, symbol, code_bits, code_length, output ready);
endinterface

interface hcbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_in_run;
  logic       end_of_stream;

  modport source (output valid, out_byte, last_in_run, end_of_stream, input ready);
  modport sink   (input valid, out_byte, last_in_run, end_of_stream, output ready);
endinterface

// ===== hw/rtl/hcbp_front.sv =====
// ----------------------------------------------------------------------------
// hcbp_front
// Accepts items, keeps the code table and turns encodes and flushes into jobs.
// ----------------------------------------------------------------------------
module hcbp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  kind,
  input  logic [hcbp_pkg::SYM_BITS-1:0]   symbol,
  input  logic [hcbp_pkg::CODE_WIDTH-1:0] code_bits,
  input  logic [hcbp_pkg::LEN_BITS-1:0]   code_length,
  output logic                        push_valid,
  input  logic                        push_ready,
  output hcbp_pkg::cmd_t              push_cmd
);
  import hcbp_pkg::*;

  entry_t mem [SYMBOL_COUNT];
  entry_t rd_entry;
  logic   pend;
  logic   pend_next;
  logic   pend_flush;
  logic   accept;
  logic   is_load;
  logic   is_encode;
  logic   is_flush;
  logic [LEN_BITS-1:0] sat_len;

  assign in_ready  = !pend || push_ready;
  assign accept    = in_valid && in_ready;
  assign is_load   = kind == KIND_LOAD;
  assign is_encode = kind == KIND_ENCODE;
  assign is_flush  = kind == KIND_FLUSH;
  assign sat_len   = (code_length > LEN_BITS'(CODE_WIDTH)) ? LEN_BITS'(CODE_WIDTH)
                                                          : code_length;

  // Table write on load, registered read on encode.
  always_ff @(posedge clk) begin
    if (accept && is_load) begin
      mem[symbol] <= '{code: code_bits, len: sat_len};
    end
    if (accept && is_encode) begin
      rd_entry <= mem[symbol];
    end
  end

  always_comb begin
    pend_next = pend;
    if (accept && (is_encode || is_flush)) begin
      pend_next = 1'b1;
    end else if (pend && push_ready) begin
      pend_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_flush <= is_flush;
    end
  end

  assign push_valid     = pend;
  assign push_cmd.flush = pend_flush;
  assign push_cmd.code  = rd_entry.code;
  assign push_cmd.len   = pend_flush ? '0 : rd_entry.len;

endmodule

// ===== hw/rtl/hcbp_queue.sv =====
// ----------------------------------------------------------------------------
// hcbp_queue
// Two-entry job queue between the front and the packer.
// ----------------------------------------------------------------------------
module hcbp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  hcbp_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output hcbp_pkg::cmd_t pop_cmd
);
  import hcbp_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hw/rtl/hcbp_back.sv =====
// ----------------------------------------------------------------------------
// hcbp_back
// Bit packer: merges codes into the byte buffer and drives the output register.
// ----------------------------------------------------------------------------
module hcbp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_ready,
  input  hcbp_pkg::cmd_t job,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_last,
  output logic           out_eos
);
  import hcbp_pkg::*;

  logic [BYTE_BITS-1:0] buffer;
  logic [BYTE_BITS-1:0] buffer_next;
  logic [3:0]           held;
  logic [3:0]           held_next;
  logic                 out_valid_next;
  logic [BYTE_BITS-1:0] out_byte_next;
  logic                 out_last_next;
  logic                 out_eos_next;
  logic                 sec_valid;
  logic                 sec_valid_next;
  logic [BYTE_BITS-1:0] sec_byte;
  logic [BYTE_BITS-1:0] sec_byte_next;

  logic                  slot_free;
  logic [CODE_WIDTH-1:0] code_m;
  logic [WIN_BITS-1:0]   window;
  logic [4:0]            total;
  logic [4:0]            total_m1;
  logic [1:0]            nbytes;

  assign slot_free = !out_valid || out_ready;
  assign job_ready = slot_free && !sec_valid;

  // Drop code bits past the length, then line the code up after the held bits.
  assign code_m   = job.code & ~({CODE_WIDTH{1'b1}} >> job.len);
  assign window   = {buffer, {CODE_WIDTH{1'b0}}} | ({code_m, {BYTE_BITS{1'b0}}} >> held);
  assign total    = 5'(held) + job.len;
  assign total_m1 = total - 5'd1;
  assign nbytes   = total_m1[4:3];

  always_comb begin
    buffer_next    = buffer;
    held_next      = held;
    out_valid_next = out_valid && !out_ready;
    out_byte_next  = out_byte;
    out_last_next  = out_last;
    out_eos_next   = out_eos;
    sec_valid_next = sec_valid;
    sec_byte_next  = sec_byte;
    if (slot_free && sec_valid) begin
      out_valid_next = 1'b1;
      out_byte_next  = sec_byte;
      out_last_next  = 1'b1;
      out_eos_next   = 1'b0;
      sec_valid_next = 1'b0;
    end else if (job_ready && job_valid) begin
      if (job.flush) begin
        out_valid_next = 1'b1;
        out_byte_next  = buffer;
        out_last_next  = 1'b1;
        out_eos_next   = 1'b1;
        buffer_next    = '0;
        held_next      = '0;
      end else if (job.len != '0) begin
        held_next = 4'(total - {nbytes, 3'b000});
        case (nbytes)
          2'd0: begin
            buffer_next = window[WIN_BITS-1 -: BYTE_BITS];
          end
          2'd1: begin
            buffer_next    = window[WIN_BITS-BYTE_BITS-1 -: BYTE_BITS];
            out_valid_next = 1'b1;
            out_byte_next  = window[WIN_BITS-1 -: BYTE_BITS];
            out_last_next  = 1'b1;
            out_eos_next   = 1'b0;
          end
          default: begin
            buffer_next    = window[BYTE_BITS-1:0];
            out_valid_next = 1'b1;
            out_byte_next  = window[WIN_BITS-1 -: BYTE_BITS];
            out_last_next  = 1'b0;
            out_eos_next   = 1'b0;
            sec_valid_next = 1'b1;
            sec_byte_next  = window[WIN_BITS-BYTE_BITS-1 -: BYTE_BITS];
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer    <= '0;
      held      <= '0;
      out_valid <= 1'b0;
      sec_valid <= 1'b0;
    end else begin
      buffer    <= buffer_next;
      held      <= held_next;
      out_valid <= out_valid_next;
      sec_valid <= sec_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_byte <= out_byte_next;
    out_last <= out_last_next;
    out_eos  <= out_eos_next;
    sec_byte <= sec_byte_next;
  end

endmodule

// ===== hw/rtl/huffman_code_bit_packer_core.sv =====
// An encode or flush reaches its first byte through the front register, one queue
// slot and the output register.
// Throughput: one beat a cycle for loads; encodes and flushes sustain one per cycle,
// both while the output takes bytes, except that an encode that yields two bytes
// holds the packer until its second byte has moved from the spare register into the
// output register. Reset (rst, synchronous): clears the bit buffer, the bit count,
// the job queue and all valid flags; the code table is not cleared and holds garbage until loaded.
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_core
// Huffman encoder back end: code table plus MSB-first byte packer.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_core (
  input logic  clk,
  input logic  rst,
  hcbp_in_if.sink    in_ch,
  hcbp_out_if.source out_ch
);
  import hcbp_pkg::*;

  // Front to queue.
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  // Queue to packer.
  logic job_valid;
  logic job_ready;
  cmd_t job;

  // Front: take every beat; write the table on load, look up the code on
  // encode, and hand encodes and flushes on as jobs. Loads and the unused
  // kind end here.
  hcbp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .kind        (in_ch.kind),
    .symbol      (in_ch.symbol),
    .code_bits   (in_ch.code_bits),
    .code_length (in_ch.code_length),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_cmd    (push_cmd)
  );

  // Queue: hold up to two jobs so a stalled output does not stop table loads
  // and lookups at once.
  hcbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (job_valid),
    .pop_ready  (job_ready),
    .pop_cmd    (job)
  );

  // Packer: merge code bits into the buffer, emit a full byte only when a
  // further bit arrives, and drain the buffer as the final byte on flush.
  hcbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last_in_run),
    .out_eos   (out_ch.end_of_stream)
  );

endmodule

// ===== hw/rtl/hcbp_checker.sv =====
// ----------------------------------------------------------------------------
// hcbp_checker
// Port-level checks of the bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module hcbp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_in_run,
  input logic       end_of_stream
);

  // No byte right after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // A flush byte is always the last of its run.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_stream |-> last_in_run)
    else $error("flush byte without last_in_run");

  // The first byte of a pair is followed at once by its partner.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_in_run |=> out_valid && !end_of_stream)
    else $error("second byte of an encode did not follow");

  // A stalled beat holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_in_run))
    else $error("stalled output beat changed");

endmodule

bind huffman_code_bit_packer_core hcbp_checker u_hcbp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_byte      (out_ch.out_byte),
  .last_in_run   (out_ch.last_in_run),
  .end_of_stream (out_ch.end_of_stream)
);
